[rtl/core/kpet_pkg.sv]
// ----------------------------------------------------------------------------
// kpet_pkg
// Event kinds, register indexes, flag encodings and helper functions for the
// key and pointer edge tracker.
// ----------------------------------------------------------------------------
package kpet_pkg;

    typedef enum logic [3:0] {
        KIND_KEYDOWN  = 4'd0,
        KIND_KEYUP    = 4'd1,
        KIND_REPEAT   = 4'd2,
        KIND_BTNDOWN  = 4'd3,
        KIND_BTNUP    = 4'd4,
        KIND_MOVE     = 4'd5,
        KIND_ENTER    = 4'd6,
        KIND_LEAVE    = 4'd7,
        KIND_SCROLL   = 4'd8,
        KIND_ENDFRAME = 4'd9,
        KIND_CLEAR    = 4'd10,
        KIND_QUERY    = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        REG_SHIFT_LEFT  = 3'd0,
        REG_SHIFT_RIGHT = 3'd1,
        REG_CTRL_LEFT   = 3'd2,
        REG_CTRL_RIGHT  = 3'd3,
        REG_ALT_LEFT    = 3'd4,
        REG_ALT_RIGHT   = 3'd5
    } reg_idx_t;

    localparam int unsigned NUM_REGS = 6;

    typedef logic [2:0] flags_t;

    localparam flags_t FLAG_PRESSED  = 3'b001;
    localparam flags_t FLAG_HELD     = 3'b010;
    localparam flags_t FLAG_RELEASED = 3'b100;

    localparam logic [2:0] MOD_SHIFT = 3'b001;
    localparam logic [2:0] MOD_CTRL  = 3'b010;
    localparam logic [2:0] MOD_ALT   = 3'b100;

    function automatic flags_t flag_press(input flags_t f);
        flags_t r;
        r = f | FLAG_HELD;
        if ((f & FLAG_HELD) == '0)
        begin
            r = r | FLAG_PRESSED;
        end
        return r;
    endfunction

    function automatic flags_t flag_release(input flags_t f);
        return (f & ~FLAG_HELD) | FLAG_RELEASED;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [31:0] s;
        s = a + b;
        if ((a[31] == b[31]) && (s[31] != a[31]))
        begin
            s = a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

endpackage

[rtl/core/key_and_pointer_edge_tracker.sv]
// ----------------------------------------------------------------------------
// key_and_pointer_edge_tracker
// Keyboard and mouse state tracker: per-key and per-button edge flags,
// modifier bits, pointer position, saturating 16.16 scroll accumulators.
// The result is registered from each accepted input transaction. Throughput:
// one transaction per cycle unless a stalled result holds in_ready low;
// flag stores are flip-flops, so end-of-frame and clear touch every entry in
// the same cycle. Reset: rst_n clears all state and the modifier code
// registers at once; no clearing pass.
// ----------------------------------------------------------------------------
module key_and_pointer_edge_tracker #(
    parameter int KEY_COUNT    = 256,
    parameter int BUTTON_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         kind,
    input  logic [7:0]         key_code,
    input  logic [2:0]         button,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] scroll_dx,
    input  logic signed [31:0] scroll_dy,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         key_state,
    output logic [2:0]         button_state,
    output logic [2:0]         modifiers,
    output logic signed [31:0] mouse_x,
    output logic signed [31:0] mouse_y,
    output logic signed [31:0] prev_x,
    output logic signed [31:0] prev_y,
    output logic signed [31:0] scroll_x,
    output logic signed [31:0] scroll_y,
    output logic               pointer_in_window
);
    import kpet_pkg::*;

    localparam int KIW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int BIW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    // configuration
    logic [7:0] mod_code_reg [NUM_REGS];
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    // state
    flags_t             key_flags_reg  [KEY_COUNT];
    flags_t             key_flags_next [KEY_COUNT];
    flags_t             btn_flags_reg  [BUTTON_COUNT];
    flags_t             btn_flags_next [BUTTON_COUNT];
    logic [2:0]         mod_bits_reg, mod_bits_next;
    logic signed [31:0] ptr_x_reg, ptr_x_next;
    logic signed [31:0] ptr_y_reg, ptr_y_next;
    logic signed [31:0] saved_x_reg, saved_x_next;
    logic signed [31:0] saved_y_reg, saved_y_next;
    logic signed [31:0] acc_x_reg, acc_x_next;
    logic signed [31:0] acc_y_reg, acc_y_next;
    logic               inside_reg, inside_next;

    // result register
    logic               out_valid_reg;
    logic [2:0]         key_state_reg;
    logic [2:0]         button_state_reg;
    logic [2:0]         modifiers_reg;
    logic signed [31:0] mouse_x_reg, mouse_y_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg;
    logic signed [31:0] scroll_x_reg, scroll_y_reg;
    logic               pointer_in_window_reg;

    logic           accept;
    logic           key_in_range, btn_in_range;
    logic           key_ok, btn_ok;
    logic [KIW-1:0] key_idx;
    logic [BIW-1:0] btn_idx;
    logic           is_keydown, is_keyup, is_btndown, is_btnup;
    logic           is_endframe, is_clear;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mod_code_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SHIFT_LEFT:  mod_code_reg[REG_SHIFT_LEFT]  <= pwdata[7:0];
                REG_SHIFT_RIGHT: mod_code_reg[REG_SHIFT_RIGHT] <= pwdata[7:0];
                REG_CTRL_LEFT:   mod_code_reg[REG_CTRL_LEFT]   <= pwdata[7:0];
                REG_CTRL_RIGHT:  mod_code_reg[REG_CTRL_RIGHT]  <= pwdata[7:0];
                REG_ALT_LEFT:    mod_code_reg[REG_ALT_LEFT]    <= pwdata[7:0];
                REG_ALT_RIGHT:   mod_code_reg[REG_ALT_RIGHT]   <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SHIFT_LEFT:  prdata = {24'd0, mod_code_reg[REG_SHIFT_LEFT]};
            REG_SHIFT_RIGHT: prdata = {24'd0, mod_code_reg[REG_SHIFT_RIGHT]};
            REG_CTRL_LEFT:   prdata = {24'd0, mod_code_reg[REG_CTRL_LEFT]};
            REG_CTRL_RIGHT:  prdata = {24'd0, mod_code_reg[REG_CTRL_RIGHT]};
            REG_ALT_LEFT:    prdata = {24'd0, mod_code_reg[REG_ALT_LEFT]};
            REG_ALT_RIGHT:   prdata = {24'd0, mod_code_reg[REG_ALT_RIGHT]};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- decode
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign key_in_range = 32'(key_code) < KEY_COUNT;
    assign btn_in_range = 32'(button) < BUTTON_COUNT;
    assign key_ok       = (key_code != '0) && key_in_range;
    assign btn_ok       = (button != '0) && btn_in_range;
    assign key_idx      = KIW'(key_code);
    assign btn_idx      = BIW'(button);

    assign is_keydown  = accept && (kind == KIND_KEYDOWN);
    assign is_keyup    = accept && (kind == KIND_KEYUP);
    assign is_btndown  = accept && (kind == KIND_BTNDOWN);
    assign is_btnup    = accept && (kind == KIND_BTNUP);
    assign is_endframe = accept && (kind == KIND_ENDFRAME);
    assign is_clear    = accept && (kind == KIND_CLEAR);

    // ------------------------------------------------------- flag stores
    always_comb
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            key_flags_next[i] = key_flags_reg[i];
            if (is_clear)
            begin
                key_flags_next[i] = '0;
            end
            else if (is_endframe)
            begin
                key_flags_next[i] = key_flags_reg[i] & FLAG_HELD;
            end
            else if (key_ok && (key_idx == KIW'(i)))
            begin
                if (is_keydown)
                begin
                    key_flags_next[i] = flag_press(key_flags_reg[i]);
                end
                else if (is_keyup)
                begin
                    key_flags_next[i] = flag_release(key_flags_reg[i]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            btn_flags_next[i] = btn_flags_reg[i];
            if (is_clear)
            begin
                btn_flags_next[i] = '0;
            end
            else if (is_endframe)
            begin
                btn_flags_next[i] = btn_flags_reg[i] & FLAG_HELD;
            end
            else if (btn_ok && (btn_idx == BIW'(i)))
            begin
                if (is_btndown)
                begin
                    btn_flags_next[i] = flag_press(btn_flags_reg[i]);
                end
                else if (is_btnup)
                begin
                    btn_flags_next[i] = flag_release(btn_flags_reg[i]);
                end
            end
        end
    end

    // ------------------------------------------------------ scalar state
    always_comb
    begin
        logic [2:0] mod_hit;
        mod_hit       = '0;
        mod_bits_next = mod_bits_reg;
        ptr_x_next    = ptr_x_reg;
        ptr_y_next    = ptr_y_reg;
        saved_x_next  = saved_x_reg;
        saved_y_next  = saved_y_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        inside_next   = inside_reg;

        // shift wins over ctrl, ctrl over alt
        priority if (key_code == mod_code_reg[REG_SHIFT_LEFT] ||
                     key_code == mod_code_reg[REG_SHIFT_RIGHT])
        begin
            mod_hit = MOD_SHIFT;
        end
        else if (key_code == mod_code_reg[REG_CTRL_LEFT] ||
                 key_code == mod_code_reg[REG_CTRL_RIGHT])
        begin
            mod_hit = MOD_CTRL;
        end
        else if (key_code == mod_code_reg[REG_ALT_LEFT] ||
                 key_code == mod_code_reg[REG_ALT_RIGHT])
        begin
            mod_hit = MOD_ALT;
        end
        else
        begin
            mod_hit = '0;
        end

        if (accept)
        begin
            unique case (kind)
                KIND_KEYDOWN:
                begin
                    if (key_ok)
                    begin
                        mod_bits_next = mod_bits_reg | mod_hit;
                    end
                end
                KIND_KEYUP:
                begin
                    if (key_ok)
                    begin
                        mod_bits_next = mod_bits_reg & ~mod_hit;
                    end
                end
                KIND_BTNDOWN, KIND_BTNUP:
                begin
                    if (btn_ok)
                    begin
                        ptr_x_next = pos_x;
                        ptr_y_next = pos_y;
                    end
                end
                KIND_MOVE:
                begin
                    ptr_x_next = pos_x;
                    ptr_y_next = pos_y;
                end
                KIND_ENTER: inside_next = 1'b1;
                KIND_LEAVE: inside_next = 1'b0;
                KIND_SCROLL:
                begin
                    acc_x_next = sat_add(acc_x_reg, scroll_dx);
                    acc_y_next = sat_add(acc_y_reg, scroll_dy);
                end
                KIND_ENDFRAME:
                begin
                    saved_x_next = ptr_x_reg;
                    saved_y_next = ptr_y_reg;
                    acc_x_next   = '0;
                    acc_y_next   = '0;
                end
                KIND_CLEAR:
                begin
                    mod_bits_next = '0;
                    ptr_x_next    = '0;
                    ptr_y_next    = '0;
                    saved_x_next  = '0;
                    saved_y_next  = '0;
                    acc_x_next    = '0;
                    acc_y_next    = '0;
                    inside_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                key_flags_reg[i] <= '0;
            end
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                btn_flags_reg[i] <= '0;
            end
            mod_bits_reg <= '0;
            ptr_x_reg    <= '0;
            ptr_y_reg    <= '0;
            saved_x_reg  <= '0;
            saved_y_reg  <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            inside_reg   <= 1'b0;
        end
        else
        begin
            key_flags_reg <= key_flags_next;
            btn_flags_reg <= btn_flags_next;
            mod_bits_reg  <= mod_bits_next;
            ptr_x_reg     <= ptr_x_next;
            ptr_y_reg     <= ptr_y_next;
            saved_x_reg   <= saved_x_next;
            saved_y_reg   <= saved_y_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            inside_reg    <= inside_next;
        end
    end

    // --------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_state_reg         <= key_in_range ? key_flags_next[key_idx] : '0;
            button_state_reg      <= btn_in_range ? btn_flags_next[btn_idx] : '0;
            modifiers_reg         <= mod_bits_next;
            mouse_x_reg           <= ptr_x_next;
            mouse_y_reg           <= ptr_y_next;
            prev_x_reg            <= saved_x_next;
            prev_y_reg            <= saved_y_next;
            scroll_x_reg          <= acc_x_next;
            scroll_y_reg          <= acc_y_next;
            pointer_in_window_reg <= inside_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign key_state         = key_state_reg;
    assign button_state      = button_state_reg;
    assign modifiers         = modifiers_reg;
    assign mouse_x           = mouse_x_reg;
    assign mouse_y           = mouse_y_reg;
    assign prev_x            = prev_x_reg;
    assign prev_y            = prev_y_reg;
    assign scroll_x          = scroll_x_reg;
    assign scroll_y          = scroll_y_reg;
    assign pointer_in_window = pointer_in_window_reg;

endmodule

[rtl/core/kpet_checker.sv]
// ----------------------------------------------------------------------------
// kpet_checker
// Port-level checks for the key and pointer edge tracker, bound to the top.
// ----------------------------------------------------------------------------
module kpet_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [3:0]         kind,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         key_state,
    input logic [2:0]         button_state,
    input logic [2:0]         modifiers,
    input logic signed [31:0] mouse_x,
    input logic signed [31:0] mouse_y,
    input logic signed [31:0] prev_x,
    input logic signed [31:0] prev_y,
    input logic signed [31:0] scroll_x,
    input logic signed [31:0] scroll_y,
    input logic               pointer_in_window
);
    import kpet_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mouse_x) &&
            $stable(scroll_x) && $stable(key_state))
        else $error("stalled result changed");

    // no new transaction while a result waits unconsumed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken over a pending result");

    // every accepted transaction gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("missing result");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_CLEAR |=>
            key_state == '0 && button_state == '0 && modifiers == '0 &&
            mouse_x == '0 && mouse_y == '0 && prev_x == '0 && prev_y == '0 &&
            scroll_x == '0 && scroll_y == '0 && !pointer_in_window)
        else $error("clear left state behind");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_ENDFRAME |=>
            scroll_x == '0 && scroll_y == '0 && prev_x == mouse_x &&
            prev_y == mouse_y && !key_state[0] && !key_state[2] &&
            !button_state[0] && !button_state[2])
        else $error("end of frame incomplete");

endmodule

bind key_and_pointer_edge_tracker kpet_checker u_kpet_checker (.*);

[sim/kpet_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpet_tb_pkg
// Transaction types and the scoreboard for the key and pointer edge tracker
// bench. The scoreboard keeps its own copy of the key, button, modifier,
// pointer, scroll and window state. For every accepted event it works out
// the state view the block must return, and checks each returned view
// against the oldest one waiting.
// ----------------------------------------------------------------------------
package kpet_tb_pkg;

    import kpet_pkg::*;

    localparam int KEY_COUNT    = 256;
    localparam int BUTTON_COUNT = 8;

    localparam logic [3:0] KIND_UNUSED_FIRST = 4'd12;
    localparam logic [3:0] KIND_UNUSED_LAST  = 4'd15;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  key_code;
        logic [2:0]  button;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] scroll_dx;
        logic [31:0] scroll_dy;
    } input_event_t;

    typedef struct packed {
        logic [2:0]  key_state;
        logic [2:0]  button_state;
        logic [2:0]  modifiers;
        logic [31:0] mouse_x;
        logic [31:0] mouse_y;
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic [31:0] scroll_x;
        logic [31:0] scroll_y;
        logic        pointer_in_window;
    } tracker_view_t;

    class input_state_scoreboard;

        flags_t        key_flags[KEY_COUNT];
        flags_t        button_flags[BUTTON_COUNT];
        logic [2:0]    mod_bits;
        logic [31:0]   ptr_x;
        logic [31:0]   ptr_y;
        logic [31:0]   saved_x;
        logic [31:0]   saved_y;
        logic [31:0]   scroll_acc_x;
        logic [31:0]   scroll_acc_y;
        logic          in_window;
        logic [7:0]    mod_code[NUM_REGS];

        tracker_view_t pending_views[$];

        int unsigned   accepted;
        int unsigned   checked;
        int unsigned   mismatches;
        int unsigned   saturations;
        int unsigned   frames;
        int unsigned   clears;

        function new();
            clear_all();
            foreach (mod_code[i])
            begin
                mod_code[i] = '0;
            end
            accepted    = 0;
            checked     = 0;
            mismatches  = 0;
            saturations = 0;
            frames      = 0;
            clears      = 0;
        endfunction

        function void clear_all();
            foreach (key_flags[i])
            begin
                key_flags[i] = '0;
            end
            foreach (button_flags[i])
            begin
                button_flags[i] = '0;
            end
            mod_bits     = '0;
            ptr_x        = '0;
            ptr_y        = '0;
            saved_x      = '0;
            saved_y      = '0;
            scroll_acc_x = '0;
            scroll_acc_y = '0;
            in_window    = 1'b0;
        endfunction

        function void set_code(reg_idx_t idx, logic [7:0] value);
            mod_code[idx] = value;
        endfunction

        function int pending();
            return pending_views.size();
        endfunction

        // first matching modifier wins: shift, then ctrl, then alt
        function void track_modifier(logic [7:0] code, bit down);
            bit matched;
            matched = 1'b0;
            for (int m = 0; m < 3; m++)
            begin
                if (!matched && (code == mod_code[2*m] || code == mod_code[2*m+1]))
                begin
                    matched     = 1'b1;
                    mod_bits[m] = down;
                end
            end
        endfunction

        function flags_t pressed_flags(flags_t f);
            if ((f & FLAG_HELD) == '0)
            begin
                f = f | FLAG_PRESSED;
            end
            return f | FLAG_HELD;
        endfunction

        function logic [31:0] scroll_sum(logic [31:0] acc, logic [31:0] delta);
            logic [32:0] wide;
            wide = {acc[31], acc} + {delta[31], delta};
            if (wide[32] != wide[31])
            begin
                saturations++;
                return wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            return wide[31:0];
        endfunction

        function void note_event(input_event_t ev);
            bit            key_ok;
            bit            btn_ok;
            tracker_view_t v;
            key_ok = (ev.key_code != 0) && (ev.key_code < KEY_COUNT);
            btn_ok = (ev.button != 0) && (ev.button < BUTTON_COUNT);
            case (ev.kind)
                KIND_KEYDOWN:
                begin
                    if (key_ok)
                    begin
                        key_flags[ev.key_code] = pressed_flags(key_flags[ev.key_code]);
                        track_modifier(ev.key_code, 1'b1);
                    end
                end
                KIND_KEYUP:
                begin
                    if (key_ok)
                    begin
                        key_flags[ev.key_code] =
                            (key_flags[ev.key_code] & ~FLAG_HELD) | FLAG_RELEASED;
                        track_modifier(ev.key_code, 1'b0);
                    end
                end
                KIND_BTNDOWN:
                begin
                    if (btn_ok)
                    begin
                        button_flags[ev.button] = pressed_flags(button_flags[ev.button]);
                        ptr_x = ev.pos_x;
                        ptr_y = ev.pos_y;
                    end
                end
                KIND_BTNUP:
                begin
                    if (btn_ok)
                    begin
                        button_flags[ev.button] =
                            (button_flags[ev.button] & ~FLAG_HELD) | FLAG_RELEASED;
                        ptr_x = ev.pos_x;
                        ptr_y = ev.pos_y;
                    end
                end
                KIND_MOVE:
                begin
                    ptr_x = ev.pos_x;
                    ptr_y = ev.pos_y;
                end
                KIND_ENTER:
                begin
                    in_window = 1'b1;
                end
                KIND_LEAVE:
                begin
                    in_window = 1'b0;
                end
                KIND_SCROLL:
                begin
                    scroll_acc_x = scroll_sum(scroll_acc_x, ev.scroll_dx);
                    scroll_acc_y = scroll_sum(scroll_acc_y, ev.scroll_dy);
                end
                KIND_ENDFRAME:
                begin
                    foreach (key_flags[i])
                    begin
                        key_flags[i] = key_flags[i] & FLAG_HELD;
                    end
                    foreach (button_flags[i])
                    begin
                        button_flags[i] = button_flags[i] & FLAG_HELD;
                    end
                    saved_x      = ptr_x;
                    saved_y      = ptr_y;
                    scroll_acc_x = '0;
                    scroll_acc_y = '0;
                    frames++;
                end
                KIND_CLEAR:
                begin
                    clear_all();
                    clears++;
                end
                default:
                begin
                end
            endcase
            v.key_state         = (ev.key_code < KEY_COUNT) ? key_flags[ev.key_code] : '0;
            v.button_state      = (ev.button < BUTTON_COUNT) ? button_flags[ev.button] : '0;
            v.modifiers         = mod_bits;
            v.mouse_x           = ptr_x;
            v.mouse_y           = ptr_y;
            v.prev_x            = saved_x;
            v.prev_y            = saved_y;
            v.scroll_x          = scroll_acc_x;
            v.scroll_y          = scroll_acc_y;
            v.pointer_in_window = in_window;
            pending_views.push_back(v);
            accepted++;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("result %0d %s: got %h, expected %h",
                                 checked, name, got, want));
            end
        endtask

        task check_view(tracker_view_t got);
            tracker_view_t want;
            if (pending_views.size() == 0)
            begin
                report("result with no transaction waiting");
                return;
            end
            want = pending_views.pop_front();
            compare_field("key_state", 32'(got.key_state), 32'(want.key_state));
            compare_field("button_state", 32'(got.button_state), 32'(want.button_state));
            compare_field("modifiers", 32'(got.modifiers), 32'(want.modifiers));
            compare_field("mouse_x", got.mouse_x, want.mouse_x);
            compare_field("mouse_y", got.mouse_y, want.mouse_y);
            compare_field("prev_x", got.prev_x, want.prev_x);
            compare_field("prev_y", got.prev_y, want.prev_y);
            compare_field("scroll_x", got.scroll_x, want.scroll_x);
            compare_field("scroll_y", got.scroll_y, want.scroll_y);
            compare_field("pointer_in_window", 32'(got.pointer_in_window),
                          32'(want.pointer_in_window));
            checked++;
        endtask

    endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key and pointer edge tracker. A directed run
// covers field extremes, every event kind, edge flag rules, modifier code
// matching, scroll saturation, end of frame and clear. Random runs follow
// under four sets of modifier codes and four pacing modes on both sides of
// the handshake, with every result checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import kpet_pkg::*;
    import kpet_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 350;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [3:0]         kind = '0;
    logic [7:0]         key_code = '0;
    logic [2:0]         button = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] scroll_dx = '0;
    logic signed [31:0] scroll_dy = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         key_state;
    logic [2:0]         button_state;
    logic [2:0]         modifiers;
    logic signed [31:0] mouse_x;
    logic signed [31:0] mouse_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] scroll_x;
    logic signed [31:0] scroll_y;
    logic               pointer_in_window;

    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int unsigned        cycle_count = 0;

    input_state_scoreboard sb;

    key_and_pointer_edge_tracker DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .key_code          (key_code),
        .button            (button),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .scroll_dx         (scroll_dx),
        .scroll_dy         (scroll_dy),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .key_state         (key_state),
        .button_state      (button_state),
        .modifiers         (modifiers),
        .mouse_x           (mouse_x),
        .mouse_y           (mouse_y),
        .prev_x            (prev_x),
        .prev_y            (prev_y),
        .scroll_x          (scroll_x),
        .scroll_y          (scroll_y),
        .pointer_in_window (pointer_in_window)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout: run stalled after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        tracker_view_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.key_state         = key_state;
            seen.button_state      = button_state;
            seen.modifiers         = modifiers;
            seen.mouse_x           = mouse_x;
            seen.mouse_y           = mouse_y;
            seen.prev_x            = prev_x;
            seen.prev_y            = prev_y;
            seen.scroll_x          = scroll_x;
            seen.scroll_y          = scroll_y;
            seen.pointer_in_window = pointer_in_window;
            sb.check_view(seen);
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input reg_idx_t idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(4 * idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_codes(input logic [7:0] codes[NUM_REGS]);
        logic [31:0] rd;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_write(reg_idx_t'(i), {24'd0, codes[i]});
            sb.set_code(reg_idx_t'(i), codes[i]);
            apb_read(reg_idx_t'(i), rd);
            if (rd !== {24'd0, codes[i]})
            begin
                sb.report($sformatf("register %0d reads %h, written %h", i, rd, codes[i]));
            end
        end
    endtask

    // drain outstanding results, then let the clock run idle before returning
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_event(input input_event_t ev);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= ev.kind;
        key_code  <= ev.key_code;
        button    <= ev.button;
        pos_x     <= ev.pos_x;
        pos_y     <= ev.pos_y;
        scroll_dx <= ev.scroll_dx;
        scroll_dy <= ev.scroll_dy;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_event(ev);
    endtask

    function automatic input_event_t mk(logic [3:0] k, logic [7:0] key, logic [2:0] btn,
                                        logic [31:0] px, logic [31:0] py,
                                        logic [31:0] dx, logic [31:0] dy);
        input_event_t ev;
        ev.kind      = k;
        ev.key_code  = key;
        ev.button    = btn;
        ev.pos_x     = px;
        ev.pos_y     = py;
        ev.scroll_dx = dx;
        ev.scroll_dy = dy;
        return ev;
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] edges[4];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        if ($urandom_range(0, 99) < 15)
        begin
            return edges[$urandom_range(0, 3)];
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_delta();
        if ($urandom_range(0, 99) < 50)
        begin
            return 32'($urandom_range(0, 32'h3FFFF)) - 32'h0002_0000;
        end
        return pick_word();
    endfunction

    // key codes lean towards the modifier codes and four ordinary keys so
    // that press, hold and release sequences actually build up
    function automatic input_event_t random_event();
        input_event_t ev;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 30)       ev.kind = KIND_KEYDOWN;
        else if (r < 55)  ev.kind = KIND_KEYUP;
        else if (r < 60)  ev.kind = KIND_REPEAT;
        else if (r < 70)  ev.kind = KIND_BTNDOWN;
        else if (r < 78)  ev.kind = KIND_BTNUP;
        else if (r < 84)  ev.kind = KIND_MOVE;
        else if (r < 86)  ev.kind = KIND_ENTER;
        else if (r < 88)  ev.kind = KIND_LEAVE;
        else if (r < 94)  ev.kind = KIND_SCROLL;
        else if (r < 97)  ev.kind = KIND_ENDFRAME;
        else if (r < 98)  ev.kind = KIND_CLEAR;
        else if (r < 99)  ev.kind = KIND_QUERY;
        else              ev.kind = 4'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        if ($urandom_range(0, 99) < 70)
        begin
            r = $urandom_range(0, 9);
            ev.key_code = (r < NUM_REGS) ? sb.mod_code[r] : 8'(r - 5);
        end
        else
        begin
            ev.key_code = 8'($urandom_range(0, 255));
        end
        ev.button    = 3'($urandom_range(0, 7));
        ev.pos_x     = pick_word();
        ev.pos_y     = pick_word();
        ev.scroll_dx = pick_delta();
        ev.scroll_dy = pick_delta();
        return ev;
    endfunction

    initial
    begin
        input_event_t plan[$];
        logic [7:0]   codes[NUM_REGS];
        logic [31:0]  rd;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_read(reg_idx_t'(i), rd);
            if (rd !== '0)
            begin
                sb.report($sformatf("register %0d reads %h after reset", i, rd));
            end
        end

        codes = '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'hFF};
        program_codes(codes);

        plan.push_back(mk(KIND_QUERY,    8'h00, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'h41, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_REPEAT,   8'h41, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'h41, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_ENDFRAME, 8'h41, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'h41, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYUP,    8'h41, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYUP,    8'h42, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'h00, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'hFF, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'h10, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYDOWN,  8'h13, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_KEYUP,    8'h11, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_BTNDOWN,  8'h00, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        plan.push_back(mk(KIND_BTNDOWN,  8'h00, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        plan.push_back(mk(KIND_BTNUP,    8'h00, 3'd1, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0));
        plan.push_back(mk(KIND_MOVE,     8'h00, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        plan.push_back(mk(KIND_ENTER,    8'h00, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_SCROLL,   8'h00, 3'd0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        plan.push_back(mk(KIND_SCROLL,   8'h00, 3'd0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF));
        plan.push_back(mk(KIND_SCROLL,   8'h00, 3'd0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        plan.push_back(mk(KIND_SCROLL,   8'h00, 3'd0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        plan.push_back(mk(KIND_LEAVE,    8'h00, 3'd0, 0, 0, 0, 0));
        plan.push_back(mk(KIND_UNUSED_FIRST, 8'hFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        plan.push_back(mk(KIND_ENDFRAME, 8'hFF, 3'd7, 0, 0, 0, 0));
        plan.push_back(mk(KIND_CLEAR,    8'hFF, 3'd7, 0, 0, 0, 0));
        plan.push_back(mk(KIND_QUERY,    8'hFF, 3'd7, 0, 0, 0, 0));
        foreach (plan[i])
        begin
            send_event(plan[i]);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    codes        = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    codes        = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                    tx_idle_pct  = 55;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    codes        = '{8'h01, 8'h20, 8'h20, 8'h21, 8'h21, 8'h00};
                    tx_idle_pct  = 0;
                    rx_stall_pct = 55;
                end
                default:
                begin
                    foreach (codes[i])
                    begin
                        codes[i] = 8'($urandom_range(1, 12));
                    end
                    tx_idle_pct  = 22;
                    rx_stall_pct = 22;
                end
            endcase
            program_codes(codes);
            repeat (RANDOM_ITEMS) send_event(random_event());
        end
        settle();

        $display("covered %0d transactions and %0d results under five modifier code sets",
                 sb.accepted, sb.checked);
        $display("and four pacing modes: %0d end-of-frame, %0d clear, %0d saturated sums",
                 sb.frames, sb.clears, sb.saturations);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[key_and_pointer_edge_tracker.f]
rtl/core/kpet_pkg.sv
rtl/core/key_and_pointer_edge_tracker.sv
rtl/core/kpet_checker.sv
sim/kpet_tb_pkg.sv
sim/tb_top.sv
